[hdl/clas_pkg.sv]
// ----------------------------------------------------------------------------
// clas_pkg: shared types and constants of the command line argument splitter
// Holds the beat payload structs, the character codes and the default for
// the backslash run limit.
// ----------------------------------------------------------------------------
package clas_pkg;

  // Default saturation limit of a counted backslash run
  localparam int unsigned DefaultMaxBackslashRun = 255;

  // Character codes that steer the split
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChBlank     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNul       = 8'h00;

  // Reported run and argument count saturate here
  localparam logic [7:0] ByteMax = 8'hFF;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_NAME = 4'b0001,
    PH_GAP  = 4'b0010,
    PH_ARG  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [7:0] backslash_run;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       arg_start;
    logic       arg_end;
    logic       arg_quoted;
    logic [7:0] arg_index;
    logic       line_done;
  } out_t;

endpackage

[hdl/command_line_argument_splitter.sv]
// ----------------------------------------------------------------------------
// command_line_argument_splitter: split a command line into arguments
// Takes a command line one byte per beat, copies the program name, splits
// the rest on blanks and tabs outside double quotes and resolves backslash
// runs before quotes into counts.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (clas_pkg::in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (clas_pkg::out_t)
//
//  Flow: one input beat per cycle while the output is not stalled. The parser
//  state and the output register are written in the same cycle a beat is
//  accepted, so a result shows on the output in the cycle after its input beat.
//  Beats with no result (gap blanks, backslashes extending a run, bytes after
//  the line end) update state only and leave the output register alone.
//  Reset: asynchronous, active low; clears the phase, counters and the output
//  valid. No clearing pass, the block is ready right after reset.
//  Stalls: in_ready_o is high whenever the output register is empty or being
//  taken in this cycle, so a stalled output holds back at most one beat.
//
module command_line_argument_splitter #(
  parameter int unsigned MAX_BACKSLASH_RUN = clas_pkg::DefaultMaxBackslashRun
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  clas_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output clas_pkg::out_t out_data_o
);
  import clas_pkg::*;

  // Width of the pending backslash counter and of its widened compare copy
  localparam int unsigned PendW = $clog2(MAX_BACKSLASH_RUN + 1);
  localparam int unsigned WideW = (PendW > 8) ? PendW : 8;

  typedef logic [PendW-1:0] pend_t;
  typedef logic [WideW-1:0] wide_t;

  localparam pend_t PendMax = PendW'(MAX_BACKSLASH_RUN);
  localparam wide_t WideByteMax = WideW'(ByteMax);

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  phase_e     phase_q, phase_d;
  logic       inq_q, inq_d;          // inside double quotes
  pend_t      pend_q, pend_d;        // counted backslash run
  logic       saw_q, saw_d;          // quoting quote seen in this argument
  logic [7:0] cnt_q, cnt_d;          // arguments begun, program name included

  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;

  logic       accept;
  logic       emit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Per-byte parse: a first byte restarts from the reset state, then the
  // phase decides how the byte is taken.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_e     ph;
    logic [7:0] c;
    logic       is_ws;
    pend_t      half;
    wide_t      wide_run;
    logic       run_nz;

    c     = in_data_i.in_byte;
    is_ws = (c == ChBlank) || (c == ChTab);

    // Restart on the first byte of a new line
    if (in_data_i.first_byte) begin
      ph     = PH_NAME;
      inq_d  = 1'b0;
      pend_d = '0;
      saw_d  = 1'b0;
      cnt_d  = '0;
    end else begin
      ph     = phase_q;
      inq_d  = inq_q;
      pend_d = pend_q;
      saw_d  = saw_q;
      cnt_d  = cnt_q;
    end
    phase_d  = ph;
    half     = pend_d >> 1;
    wide_run = '0;
    out_d    = '0;

    unique case (ph)
      PH_NAME: begin
        // Copy the program name verbatim
        if (cnt_d == '0) begin
          cnt_d           = 8'd1;
          out_d.arg_start = 1'b1;
        end
        if (c == ChNul) begin
          out_d.arg_end = 1'b1;
          phase_d       = PH_GAP;
        end else begin
          out_d.has_byte = 1'b1;
          out_d.out_byte = c;
        end
      end
      PH_GAP: begin
        // Drop whitespace; a zero ends the line, anything else opens an argument
        if (!is_ws) begin
          if (c == ChNul) begin
            out_d.line_done = 1'b1;
            phase_d         = PH_DONE;
          end else begin
            if (cnt_d != ByteMax) cnt_d = cnt_d + 8'd1;
            inq_d           = 1'b0;
            saw_d           = 1'b0;
            pend_d          = '0;
            half            = '0;
            out_d.arg_start = 1'b1;
            phase_d         = PH_ARG;
          end
        end
      end
      PH_ARG: ;
      PH_DONE: ;
      default: ;
    endcase

    if (phase_d == PH_ARG) begin
      priority if (c == ChQuote) begin
        // Half the run is emitted; an odd run makes the quote literal
        wide_run = WideW'(half);
        if (pend_d[0]) begin
          out_d.has_byte = 1'b1;
          out_d.out_byte = c;
        end else begin
          inq_d = !inq_d;
          saw_d = 1'b1;
        end
        pend_d = '0;
      end else if (c == ChBackslash) begin
        // Count the run, hold at the limit
        if (pend_d < PendMax) pend_d = pend_d + PendW'(1);
      end else begin
        // Any other byte emits the whole run
        wide_run = WideW'(pend_d);
        pend_d   = '0;
        if ((c == ChNul) || (is_ws && !inq_d)) begin
          out_d.arg_end    = 1'b1;
          out_d.arg_quoted = saw_d;
          if (c == ChNul) begin
            out_d.line_done = 1'b1;
            phase_d         = PH_DONE;
          end else begin
            phase_d = PH_GAP;
          end
        end else begin
          out_d.has_byte = 1'b1;
          out_d.out_byte = c;
        end
      end
    end

    out_d.backslash_run = (wide_run > WideByteMax) ? ByteMax : wide_run[7:0];
    run_nz              = (wide_run != '0);

    if (ph == PH_NAME) begin
      out_d.arg_index = '0;
    end else begin
      out_d.arg_index = (cnt_d != '0) ? (cnt_d - 8'd1) : '0;
    end

    emit = (ph != PH_DONE) && (run_nz || out_d.has_byte || out_d.arg_start ||
                               out_d.arg_end || out_d.line_done);

    // Output register: load on a result, clear when taken
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NAME;
      inq_q       <= 1'b0;
      pend_q      <= '0;
      saw_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        inq_q   <= inq_d;
        pend_q  <= pend_d;
        saw_q   <= saw_d;
        cnt_q   <= cnt_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_quoted_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.arg_quoted |-> out_q.arg_end)
    else $error("arg_quoted without arg_end");

  a_done_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.line_done |-> !out_q.has_byte)
    else $error("line_done beat carries a byte");

  a_byte_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.has_byte |-> (out_q.out_byte != ChNul))
    else $error("emitted argument byte is zero");

  a_done_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (pend_q == '0))
    else $error("backslash run left pending after line end");

  a_gap_not_quoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAP) && (cnt_q > 8'd1) |-> !inq_q)
    else $error("between arguments while inside quotes");

endmodule
